### rtl/vfcm_pkg.sv
package vfcm_pkg;

   // Grid extent.
   localparam int GRID_X     = 16;
   localparam int GRID_Y     = 64;
   localparam int GRID_DEPTH = 16;

   // Field widths.
   localparam int X_W    = 4;
   localparam int Y_W    = 6;
   localparam int D_W    = 4;
   localparam int TYPE_W = 8;
   localparam int VERT_W = 19;
   localparam int DIR_W  = 3;

   // Store geometry: y selects a plane, depth a row, x the entry.
   localparam int PLANE       = GRID_X * GRID_DEPTH;
   localparam int STORE_DEPTH = PLANE * GRID_Y;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int NUM_DIR = 6;
   localparam int SCAN_W  = $clog2(NUM_DIR + 1);

   localparam logic [VERT_W-1:0] COUNT_MAX = '1;
   localparam logic [VERT_W-1:0] FACE_STEP = VERT_W'(4);
   localparam logic [VERT_W-1:0] OVF_LIMIT = COUNT_MAX - FACE_STEP;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_MESH  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_FRONT  = 3'd0,
      DIR_BACK   = 3'd1,
      DIR_RIGHT  = 3'd2,
      DIR_LEFT   = 3'd3,
      DIR_TOP    = 3'd4,
      DIR_BOTTOM = 3'd5
   } direction_type;

   typedef enum logic {
      KIND_FACE = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   typedef struct packed {
      action_type        action;
      logic [X_W-1:0]    cell_x;
      logic [Y_W-1:0]    cell_y;
      logic [D_W-1:0]    cell_depth;
      logic [TYPE_W-1:0] voxel_type;
   } vfcm_req_type;

   typedef struct packed {
      kind_type          kind;
      logic [X_W-1:0]    face_x;
      logic [Y_W-1:0]    face_y;
      logic [D_W-1:0]    face_depth;
      direction_type     direction;
      logic [TYPE_W-1:0] cell_type;
      logic [VERT_W-1:0] base_vertex;
      logic              overflow;
      logic              last;
   } vfcm_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic take_req;
      logic wr_cell;
      logic zero_count;
      logic rd_self;
      logic keep_self;
      logic scan;
      logic load_read;
      logic load_face;
   } vfcm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       clear_done;
      logic       self_solid;
      logic       scan_done;
      logic       mask_empty;
      logic       mask_one;
      logic       rsp_free;
   } vfcm_status_type;

   function automatic logic in_grid(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                    logic [D_W-1:0] d);
      return (32'(x) < GRID_X) && (32'(y) < GRID_Y) && (32'(d) < GRID_DEPTH);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(logic [X_W-1:0] x,
                                                   logic [Y_W-1:0] y,
                                                   logic [D_W-1:0] d);
      return ADDR_W'(y) * ADDR_W'(PLANE) + ADDR_W'(d) * ADDR_W'(GRID_X)
             + ADDR_W'(x);
   endfunction

endpackage

### rtl/vfcm_ram.sv
module vfcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/vfcm_datapath.sv
module vfcm_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  vfcm_pkg::vfcm_req_type   req_payload,
   input  vfcm_pkg::vfcm_cmd_type   cmd,
   output vfcm_pkg::vfcm_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vfcm_pkg::vfcm_rsp_type   rsp_payload
);
   import vfcm_pkg::*;

   vfcm_req_type       req_ff, req_in;
   logic [ADDR_W-1:0]  self_addr_ff, self_addr_in;
   logic [TYPE_W-1:0]  self_type_ff, self_type_in;
   logic [SCAN_W-1:0]  scan_idx_ff, scan_idx_in;
   logic               out_prev_ff, out_prev_in;
   logic [NUM_DIR-1:0] mask_ff, mask_in;
   logic [VERT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   vfcm_rsp_type       rsp_ff, rsp_in;

   logic [ADDR_W-1:0]  ram_addr;
   logic               ram_we;
   logic [TYPE_W-1:0]  ram_wdata;
   logic [TYPE_W-1:0]  ram_rdata;

   logic               self_in_grid;
   logic [ADDR_W-1:0]  nb_addr;
   logic               nb_out;
   logic [NUM_DIR-1:0] sel_onehot;
   direction_type      sel_dir;
   logic               face_ovf;
   logic               rsp_free;

   vfcm_ram #(
      .WIDTH(TYPE_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .addr (ram_addr),
      .we   (ram_we),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign self_in_grid = in_grid(req_ff.cell_x, req_ff.cell_y, req_ff.cell_depth);
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign face_ovf     = count_ff > OVF_LIMIT;

   // Neighbor address and edge test for the direction being fetched.
   always_comb begin
      nb_addr = self_addr_ff;
      nb_out  = 1'b1;
      case (direction_type'(scan_idx_ff))
         DIR_FRONT: begin
            nb_addr = self_addr_ff - ADDR_W'(GRID_X);
            nb_out  = req_ff.cell_depth == '0;
         end
         DIR_BACK: begin
            nb_addr = self_addr_ff + ADDR_W'(GRID_X);
            nb_out  = 32'(req_ff.cell_depth) == GRID_DEPTH - 1;
         end
         DIR_RIGHT: begin
            nb_addr = self_addr_ff + ADDR_W'(1);
            nb_out  = 32'(req_ff.cell_x) == GRID_X - 1;
         end
         DIR_LEFT: begin
            nb_addr = self_addr_ff - ADDR_W'(1);
            nb_out  = req_ff.cell_x == '0;
         end
         DIR_TOP: begin
            nb_addr = self_addr_ff + ADDR_W'(PLANE);
            nb_out  = 32'(req_ff.cell_y) == GRID_Y - 1;
         end
         DIR_BOTTOM: begin
            nb_addr = self_addr_ff - ADDR_W'(PLANE);
            nb_out  = req_ff.cell_y == '0;
         end
         default: begin
            nb_addr = self_addr_ff;
            nb_out  = 1'b1;
         end
      endcase
   end

   // Lowest exposed side goes out first.
   always_comb begin
      logic found;
      found      = 1'b0;
      sel_onehot = '0;
      sel_dir    = DIR_FRONT;
      for (int i = 0; i < NUM_DIR; i++) begin
         if (mask_ff[i] && !found) begin
            found         = 1'b1;
            sel_onehot[i] = 1'b1;
            sel_dir       = direction_type'(DIR_W'(i));
         end
      end
   end

   // Store port: one access per cycle.
   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = req_payload.voxel_type;
      ram_addr  = self_addr_ff;
      if (cmd.clr_step) begin
         ram_we    = 1'b1;
         ram_wdata = '0;
         ram_addr  = clr_addr_ff;
      end else if (cmd.wr_cell) begin
         ram_we   = in_grid(req_payload.cell_x, req_payload.cell_y,
                            req_payload.cell_depth);
         ram_addr = cell_addr(req_payload.cell_x, req_payload.cell_y,
                              req_payload.cell_depth);
      end else if (cmd.rd_self) begin
         ram_addr = self_addr_ff;
      end else if (cmd.scan) begin
         ram_addr = nb_addr;
      end
   end

   always_comb begin
      req_in       = req_ff;
      self_addr_in = self_addr_ff;
      self_type_in = self_type_ff;
      scan_idx_in  = scan_idx_ff;
      out_prev_in  = out_prev_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end
      if (cmd.take_req) begin
         req_in       = req_payload;
         self_addr_in = cell_addr(req_payload.cell_x, req_payload.cell_y,
                                  req_payload.cell_depth);
      end
      if (cmd.zero_count) begin
         count_in = '0;
      end
      if (cmd.keep_self) begin
         self_type_in = self_in_grid ? ram_rdata : '0;
         scan_idx_in  = '0;
         mask_in      = '0;
      end
      if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + SCAN_W'(1);
         out_prev_in = nb_out;
         for (int i = 0; i < NUM_DIR; i++) begin
            if (scan_idx_ff == SCAN_W'(i + 1)) begin
               mask_in[i] = out_prev_ff || (ram_rdata == '0);
            end
         end
      end
      if (cmd.load_read) begin
         rsp_valid_in = 1'b1;
         rsp_in = '{kind: KIND_READ, face_x: req_ff.cell_x, face_y: req_ff.cell_y,
                    face_depth: req_ff.cell_depth, direction: DIR_FRONT,
                    cell_type: self_type_ff, base_vertex: '0, overflow: 1'b0,
                    last: 1'b1};
      end
      if (cmd.load_face) begin
         rsp_valid_in = 1'b1;
         mask_in      = mask_ff & ~sel_onehot;
         count_in     = face_ovf ? COUNT_MAX : count_ff + FACE_STEP;
         rsp_in = '{kind: KIND_FACE, face_x: req_ff.cell_x, face_y: req_ff.cell_y,
                    face_depth: req_ff.cell_depth, direction: sel_dir,
                    cell_type: self_type_ff, base_vertex: count_ff,
                    overflow: face_ovf,
                    last: (mask_ff & ~sel_onehot) == '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         mask_ff      <= '0;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_idx_ff  <= scan_idx_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      self_addr_ff <= self_addr_in;
      self_type_ff <= self_type_in;
      out_prev_ff  <= out_prev_in;
      rsp_ff       <= rsp_in;
   end

   assign status.action     = req_ff.action;
   assign status.clear_done = clr_addr_ff == ADDR_W'(STORE_DEPTH - 1);
   assign status.self_solid = self_in_grid && (ram_rdata != '0);
   assign status.scan_done  = scan_idx_ff == SCAN_W'(NUM_DIR);
   assign status.mask_empty = mask_ff == '0;
   assign status.mask_one   = (mask_ff & ~sel_onehot) == '0;
   assign status.rsp_free   = rsp_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/vfcm_ctrl.sv
module vfcm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  vfcm_pkg::action_type      req_action,
   output logic                      req_ready,
   input  vfcm_pkg::vfcm_status_type status,
   output vfcm_pkg::vfcm_cmd_type    cmd
);
   import vfcm_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_LOOKUP = 7'b0000100,
      ST_SELF   = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_FACE   = 7'b0100000,
      ST_READ   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               case (req_action)
                  ACT_WRITE: cmd.wr_cell = 1'b1;
                  ACT_CLEAR: cmd.zero_count = 1'b1;
                  ACT_READ, ACT_MESH: state_in = ST_LOOKUP;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: begin
            cmd.rd_self = 1'b1;
            state_in    = ST_SELF;
         end
         ST_SELF: begin
            cmd.keep_self = 1'b1;
            if (status.action == ACT_READ) begin
               state_in = ST_READ;
            end else if (status.self_solid) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FACE;
            end
         end
         ST_FACE: begin
            if (status.mask_empty) begin
               state_in = ST_IDLE;
            end else if (status.rsp_free) begin
               cmd.load_face = 1'b1;
               if (status.mask_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            if (status.rsp_free) begin
               cmd.load_read = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/voxel_face_culling_mesher.sv
// Culled-face voxel mesher. The block keeps a 16 x 64 x 16 grid of 8-bit voxel
// types in a single-port on-chip memory and a 19-bit vertex counter. Each request
// is a write, a read, a mesh of one cell or a counter clear. After reset the block
// sweeps the memory to air, one entry per cycle, and holds req_ready low until the
// sweep is done. A write or a counter clear is done as it is taken and answers
// nothing. A read answers one response. A mesh of an air cell (or of a cell
// outside the grid) answers nothing. A mesh of a solid cell reads the cell and
// then its six neighbors through the one memory port, front, back, right, left,
// top, bottom, and then sends one face response per exposed side at one per
// cycle while rsp_ready stays high. Only the memory port limits the lookup phase.
// Faces carry the vertex counter as the base vertex; the counter then steps by
// four and saturates at its top value, and every face issued at or past
// saturation has overflow set until a counter clear. The last response of a
// request carries last. The response sits in an output register, so a new
// request is taken while the previous response still waits.
module voxel_face_culling_mesher (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vfcm_pkg::vfcm_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vfcm_pkg::vfcm_rsp_type rsp_payload
);
   import vfcm_pkg::*;

   vfcm_cmd_type    cmd;
   vfcm_status_type status;

   // The sequencer decides what happens each cycle.
   vfcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_action(req_payload.action),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the store, the counter and the output register.
   vfcm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // A response is only loaded when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_face || cmd.load_read) |-> status.rsp_free)
      else $error("response loaded over a pending response");

   // No request is taken while the memory is being swept.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_ready)
      else $error("request taken during the clearing pass");

   // A face is only ever emitted for a solid cell.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_face |=> (rsp_valid && rsp_payload.cell_type != '0))
      else $error("face emitted for an air cell");

endmodule
